// ===== rtl/mdp_pkg.sv =====
package mdp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLOCK_SIZE    = 2'd0;
  localparam logic [1:0] REG_LENGTH_WIDE   = 2'd1;
  localparam logic [1:0] REG_LENGTH_BIG    = 2'd2;
  localparam logic [1:0] REG_LIMIT_EXP     = 2'd3;

  // Block size codes.
  localparam logic [1:0] BS_16  = 2'd0;
  localparam logic [1:0] BS_64  = 2'd1;
  localparam logic [1:0] BS_128 = 2'd2;

  // Command kinds passed from the front end to the back end.
  localparam logic [1:0] CMD_DATA   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_ERROR  = 2'd2;

  // Fixed framing constants.
  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam int unsigned LEN_BYTES_NARROW = 8;
  localparam int unsigned LEN_BYTES_WIDE   = 16;
  localparam int unsigned BIT_LEN_W        = 128;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Input item.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [63:0] word;
    logic        block_end;
    logic        last;
    logic        error;
  } out_item_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [1:0] block_size_code;
    logic       length_field_wide;
    logic       length_big_endian;
    logic [6:0] length_limit_exponent;
  } cfg_t;

  // Classified command; bit_len is only meaningful for a finish.
  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data_byte;
    logic [BIT_LEN_W-1:0] bit_len;
  } cmd_t;

endpackage

// ===== rtl/merkle_damgard_padder_top.sv =====
// Byte-stream framer that feeds a hash compression core.
// Input channel (push/full): each item is a message byte (op data) or a finish
// command. An item is taken on a clock edge with push high and full low.
// Result channel (empty/pop): 64-bit words, first byte most significant, with
// block_end on the word that closes a block and last on the final padded word
// or on an error result. A result is taken on an edge with pop high and empty low.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes block size,
// length field width, length endianness and the length limit exponent; write it
// only while no item is in flight.
// Taken items enter the command queue; results leave through the result queue.
// Throughput: one message byte per cycle while the result queue has room and no
// finish is being padded. A finish produces one padded word per cycle from the
// padding sequencer while the result queue has room, 2 to 18 words, and the next
// item is taken meanwhile into the command queue, two items deep.
// When the receiver stalls, the two-entry result queue fills, the sequencer
// holds, and full rises once the command queue is also full; nothing is lost.
// Reset clears the length counter, the block position, both queues and loads
// the default configuration (64-byte blocks, 8-byte big-endian length, 2^61 limit).
module merkle_damgard_padder_top #(
  parameter int MAX_BLOCK_BYTES     = 128,
  parameter int LENGTH_COUNTER_BITS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mdp_pkg::in_item_t  cmd,
  output logic               empty,
  input  logic               pop,
  output mdp_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;
  localparam int CMD_W     = $bits(mdp_pkg::cmd_t);
  localparam int RES_W     = $bits(mdp_pkg::out_item_t);

  mdp_pkg::cfg_t      cfg;
  mdp_pkg::cmd_t      front_cmd;
  mdp_pkg::cmd_t      head_cmd;
  mdp_pkg::out_item_t back_res;
  logic               cmd_write;
  logic               cmd_pop;
  logic               cmd_empty;
  logic               res_write;
  logic               res_full;
  logic [CMD_W-1:0]   head_bits;
  logic [RES_W-1:0]   res_bits;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size_code       <= mdp_pkg::BS_64;
      cfg.length_field_wide     <= 1'b0;
      cfg.length_big_endian     <= 1'b1;
      cfg.length_limit_exponent <= 7'd61;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdp_pkg::REG_BLOCK_SIZE:  cfg.block_size_code       <= cfg_data[1:0];
        mdp_pkg::REG_LENGTH_WIDE: cfg.length_field_wide     <= cfg_data[0];
        mdp_pkg::REG_LENGTH_BIG:  cfg.length_big_endian     <= cfg_data[0];
        mdp_pkg::REG_LIMIT_EXP:   cfg.length_limit_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: length counting and limit check.
  mdp_front #(
    .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (push && !full),
    .item     (cmd),
    .cfg      (cfg),
    .cmd_write(cmd_write),
    .cmd      (front_cmd)
  );

  // Command queue between the front end and the framing engine.
  mdp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_write),
    .wr_data(front_cmd),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(head_bits),
    .empty  (cmd_empty)
  );

  assign head_cmd = head_bits;

  // Back end: word packing and padding sequencer.
  mdp_back #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd      (head_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_write(res_write),
    .res      (back_res)
  );

  // Result queue toward the compression core.
  mdp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_write),
    .wr_data(back_res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_bits),
    .empty  (empty)
  );

  assign result = res_bits;

endmodule

// ===== rtl/mdp_fifo.sv =====
module mdp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage is written at the tail pointer.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mdp_front.sv =====
module mdp_front #(
  parameter int LENGTH_COUNTER_BITS = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  mdp_pkg::in_item_t item,
  input  mdp_pkg::cfg_t   cfg,
  output logic            cmd_write,
  output mdp_pkg::cmd_t   cmd
);

  localparam int LCB = LENGTH_COUNTER_BITS;

  logic [LCB-1:0] byte_count;
  logic [LCB-1:0] count_next;
  logic [LCB-1:0] upper_mask;
  logic           limit_on;
  logic           over;

  assign count_next = byte_count + 1'b1;
  assign limit_on   = (cfg.length_limit_exponent != 7'd0) &&
                      ({1'b0, cfg.length_limit_exponent} < 8'(LCB));

  // Bits at or above the limit exponent; any of them set means the limit is hit.
  always_comb begin
    for (int b = 0; b < LCB; b++) begin
      upper_mask[b] = (8'(b) >= {1'b0, cfg.length_limit_exponent});
    end
  end

  assign over = limit_on && ((count_next & upper_mask) != '0);

  // Classify the item and hand the length over with a finish.
  always_comb begin
    cmd_write     = accept;
    cmd.data_byte = item.data_byte;
    cmd.bit_len   = mdp_pkg::BIT_LEN_W'(byte_count) << 3;
    if (item.op == mdp_pkg::OP_FINISH) begin
      cmd.kind = mdp_pkg::CMD_FINISH;
    end else if (over) begin
      cmd.kind = mdp_pkg::CMD_ERROR;
    end else begin
      cmd.kind = mdp_pkg::CMD_DATA;
    end
  end

  // Message length counter, cleared when a message is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (item.op == mdp_pkg::OP_FINISH) begin
        byte_count <= '0;
      end else if (!over) begin
        byte_count <= count_next;
      end
    end
  end

endmodule

// ===== rtl/mdp_back.sv =====
module mdp_back #(
  parameter int MAX_BLOCK_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  mdp_pkg::cfg_t      cfg,
  input  logic               cmd_empty,
  input  mdp_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_write,
  output mdp_pkg::out_item_t res
);

  localparam int PW = $clog2(MAX_BLOCK_BYTES);

  // Block length after clamping the code and falling back to a size that fits.
  function automatic logic [8:0] block_len(input logic [1:0] code);
    logic [1:0] c;
    logic [8:0] len;
    c = (code > mdp_pkg::BS_128) ? mdp_pkg::BS_128 : code;
    if (c == mdp_pkg::BS_128 && MAX_BLOCK_BYTES < 128) c = mdp_pkg::BS_64;
    if (c == mdp_pkg::BS_64 && MAX_BLOCK_BYTES < 64) c = mdp_pkg::BS_16;
    unique case (c)
      mdp_pkg::BS_16: len = 9'd16;
      mdp_pkg::BS_64: len = 9'd64;
      default:        len = 9'd128;
    endcase
    return len;
  endfunction

  logic [PW-1:0] pos;
  logic [55:0]   asm_word;
  logic          fin_busy;
  logic          arm;

  logic [8:0]  blen;
  logic [4:0]  lbytes;
  logic [8:0]  target;
  logic [8:0]  pos9;
  logic [2:0]  fill;
  logic [8:0]  room_blk;
  logic [8:0]  room_word;
  logic [8:0]  n;
  logic [8:0]  p;
  logic        blk_end;
  logic        is_data;
  logic        is_fin;
  logic        is_err;
  logic        first;
  logic        arm_cur;
  logic        emit;
  logic        proceed;
  logic        final_word;
  logic [63:0] lanes;
  logic [63:0] new_word;
  logic [8:0]  q;
  logic [8:0]  li;
  logic [3:0]  jsel;
  logic [7:0]  len_byte;
  logic [7:0]  lane_byte;
  logic        in_rng;

  assign blen    = block_len(cfg.block_size_code);
  assign lbytes  = cfg.length_field_wide ? 5'(mdp_pkg::LEN_BYTES_WIDE)
                                         : 5'(mdp_pkg::LEN_BYTES_NARROW);
  assign target  = blen - 9'(lbytes);
  assign pos9    = 9'(pos);
  assign fill    = pos9[2:0];
  assign is_data = (cmd.kind == mdp_pkg::CMD_DATA);
  assign is_fin  = (cmd.kind == mdp_pkg::CMD_FINISH);
  assign is_err  = !is_data && !is_fin;
  assign first   = !fin_busy;
  assign arm_cur = fin_busy ? arm : (pos9 < target);

  // Bytes taken this cycle: one for data, up to the word or block boundary for padding.
  always_comb begin
    room_word = 9'd8 - 9'(fill);
    room_blk  = (pos9 < blen) ? (blen - pos9) : 9'd1;
    if (is_data) begin
      n = 9'd1;
    end else begin
      n = (room_word < room_blk) ? room_word : room_blk;
    end
    p       = pos9 + n;
    blk_end = (p >= blen);
  end

  assign emit       = is_err || is_fin || (p[2:0] == 3'd0) || blk_end;
  assign final_word = is_fin && blk_end && arm_cur;
  assign proceed    = !cmd_empty && (!emit || !res_full);

  // Fill the byte lanes of the word: message byte, pad marker, zero or length byte.
  always_comb begin
    lanes     = '0;
    q         = '0;
    li        = '0;
    jsel      = '0;
    len_byte  = '0;
    lane_byte = '0;
    in_rng    = 1'b0;
    for (int j = 0; j < 8; j++) begin
      in_rng = (9'(j) >= 9'(fill)) && (9'(j) < 9'(fill) + n);
      q      = pos9 + 9'(j) - 9'(fill);
      li     = q - target;
      if (cfg.length_big_endian) begin
        jsel = 4'(lbytes - 5'd1) - li[3:0];
      end else begin
        jsel = li[3:0];
      end
      len_byte = cmd.bit_len[{jsel, 3'b000} +: 8];
      if (is_data) begin
        lane_byte = cmd.data_byte;
      end else if (first && 9'(j) == 9'(fill)) begin
        lane_byte = mdp_pkg::PAD_BYTE;
      end else if (arm_cur && q >= target) begin
        lane_byte = len_byte;
      end else begin
        lane_byte = 8'h00;
      end
      if (in_rng) begin
        lanes[63-8*j -: 8] = lane_byte;
      end
    end
  end

  assign new_word = {asm_word, 8'h00} | lanes;

  // Result formatting.
  always_comb begin
    cmd_pop   = proceed && (is_data || is_err || final_word);
    res_write = proceed && emit;
    if (is_err) begin
      res.word      = '0;
      res.block_end = 1'b0;
      res.last      = 1'b1;
      res.error     = 1'b1;
    end else begin
      res.word      = new_word;
      res.block_end = blk_end;
      res.last      = final_word;
      res.error     = 1'b0;
    end
  end

  // Block position, partial word and padding progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      asm_word <= '0;
      fin_busy <= 1'b0;
      arm      <= 1'b0;
    end else if (proceed && !is_err) begin
      if (emit) begin
        asm_word <= '0;
      end else begin
        asm_word <= new_word[63:8];
      end
      if (blk_end) begin
        pos <= '0;
      end else begin
        pos <= PW'(p);
      end
      if (is_fin) begin
        if (final_word) begin
          fin_busy <= 1'b0;
          arm      <= 1'b0;
        end else begin
          fin_busy <= 1'b1;
          arm      <= arm_cur || blk_end;
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int unsigned RANDOM_ITEMS   = 320;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES    = 90;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_RARE} rx_mode_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic [7:0]         data_byte;
    logic [1:0]         reg_index;
    logic [6:0]         reg_value;
    mdp_pkg::out_item_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  mdp_pkg::in_item_t  cmd = '0;
  logic               empty;
  logic               pop = 1'b0;
  mdp_pkg::out_item_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [6:0]         cfg_data = '0;

  // Checked rows carry their own expected word alongside the item on the bus.
  logic               row_typed = 1'b0;
  mdp_pkg::out_item_t row_want = '0;

  // Framing model: configuration and message state.
  logic [1:0]   m_block_code;
  logic         m_len_wide;
  logic         m_len_big;
  logic [6:0]   m_limit_exp;
  logic [6:0]   m_pos;
  logic [63:0]  m_word;
  logic [127:0] m_count;

  mdp_pkg::out_item_t framed_words[$];
  mdp_pkg::out_item_t pending_words[$];

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_cycles = 0;
  logic        tx_idle = 1'b0;
  logic        hold_req = 1'b0;
  rx_mode_t    rx_mode = RX_ALWAYS;

  plan_row_t plan[$];

  merkle_damgard_padder_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Block length in bytes; the unused code behaves as the largest size.
  function automatic int unsigned block_bytes();
    case (m_block_code)
      mdp_pkg::BS_16: return 16;
      mdp_pkg::BS_64: return 64;
      default:        return 128;
    endcase
  endfunction

  // Places one byte into the current word and emits the word when it or the block closes.
  task automatic place_byte(input logic [7:0] b, input logic fin);
    int unsigned        p;
    int unsigned        fill;
    logic               close;
    mdp_pkg::out_item_t r;
    p = m_pos + 1;
    fill = p % 8;
    close = (p >= block_bytes());
    m_word = {m_word[55:0], b};
    if (fill == 0 || close) begin
      r.word = m_word;
      if (fill != 0) r.word = r.word << (8 * (8 - fill));
      r.block_end = close;
      r.last = fin;
      r.error = 1'b0;
      framed_words.push_back(r);
      m_word = '0;
      m_pos = close ? 7'd0 : 7'(p);
    end else begin
      m_pos = 7'(p);
    end
  endtask

  // Works out the words that one input item produces.
  task automatic frame_item(input mdp_pkg::in_item_t it);
    logic [127:0]       next_count;
    logic [127:0]       bit_len;
    int unsigned        lbytes;
    int unsigned        target;
    int unsigned        j;
    int unsigned        i;
    mdp_pkg::out_item_t r;
    framed_words.delete();
    if (it.op == mdp_pkg::OP_DATA) begin
      next_count = m_count + 1;
      if (m_limit_exp != 0 && (next_count >> m_limit_exp) != 0) begin
        // Over the length limit: the byte is dropped and flagged.
        r.word = '0;
        r.block_end = 1'b0;
        r.last = 1'b1;
        r.error = 1'b1;
        framed_words.push_back(r);
      end else begin
        m_count = next_count;
        place_byte(it.data_byte, 1'b0);
      end
    end else begin
      lbytes = m_len_wide ? mdp_pkg::LEN_BYTES_WIDE : mdp_pkg::LEN_BYTES_NARROW;
      target = block_bytes() - lbytes;
      bit_len = m_count << 3;
      place_byte(mdp_pkg::PAD_BYTE, 1'b0);
      while (m_pos != target) place_byte(8'h00, 1'b0);
      for (i = 0; i < lbytes; i++) begin
        j = m_len_big ? (lbytes - 1 - i) : i;
        place_byte(bit_len[8*j +: 8], (i + 1 == lbytes));
      end
      m_pos = '0;
      m_word = '0;
      m_count = '0;
    end
  endtask

  // Scoreboard: compares results, tracks configuration writes and predicts accepted items.
  always @(posedge clk) begin
    mdp_pkg::out_item_t want;
    if (rst) begin
      m_block_code = mdp_pkg::BS_64;
      m_len_wide = 1'b0;
      m_len_big = 1'b1;
      m_limit_exp = 7'd61;
      m_pos = '0;
      m_word = '0;
      m_count = '0;
      pending_words.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: word=%h block_end=%b last=%b error=%b",
                     result.word, result.block_end, result.last, result.error);
        end else begin
          want = pending_words.pop_front();
          if (result.word !== want.word || result.block_end !== want.block_end ||
              result.last !== want.last || result.error !== want.error) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                       want.word, want.block_end, want.last, want.error,
                       result.word, result.block_end, result.last, result.error);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mdp_pkg::REG_BLOCK_SIZE:  m_block_code = cfg_data[1:0];
          mdp_pkg::REG_LENGTH_WIDE: m_len_wide = cfg_data[0];
          mdp_pkg::REG_LENGTH_BIG:  m_len_big = cfg_data[0];
          mdp_pkg::REG_LIMIT_EXP:   m_limit_exp = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        frame_item(cmd);
        if (row_typed) pending_words.push_back(row_want);
        else foreach (framed_words[k]) pending_words.push_back(framed_words[k]);
      end
    end
  end

  // Watchdog: ends the run when no item moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_words.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Result side: pop follows the current stall pattern, or holds off on request.
  initial begin
    int unsigned tick;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  pop = 1'b1;
          RX_RANDOM:  pop = $urandom_range(0, 1);
          RX_PATTERN: pop = (tick % 8) > 2;
          default:    pop = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offers one item and waits until the block takes it; inserts gaps between bursts.
  task automatic send_item(input logic op, input logic [7:0] data, input logic typed,
                           input mdp_pkg::out_item_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = tx_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push = 1'b1;
    cmd.op = op;
    cmd.data_byte = data;
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Stops offering items and waits until every expected word has come out.
  task automatic drain(input int unsigned extra);
    @(negedge clk);
    push = 1'b0;
    row_typed = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one random data byte as an item of an open message.
  task automatic send_byte();
    send_item(mdp_pkg::OP_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Sends one message of random bytes, then the finish command.
  task automatic send_message(input int unsigned len);
    repeat (len) send_byte();
    send_item(mdp_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  function automatic plan_row_t item_row(input logic op, input logic [7:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.data_byte = data;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [7:0] data, input logic [63:0] word,
                                            input logic last, input logic error);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CHECKED;
    r.op = mdp_pkg::OP_DATA;
    r.data_byte = data;
    r.want.word = word;
    r.want.last = last;
    r.want.error = error;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [6:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  // Stimulus: directed table first, then random phases under changing settings.
  initial begin
    int unsigned phase;
    int unsigned quota;
    int unsigned len;
    logic [1:0]  bsize;
    logic [6:0]  lexp;

    // Empty message after reset, with the data byte of the finish ignored.
    plan.push_back(item_row(mdp_pkg::OP_FINISH, 8'hFF));
    // One full word with the byte extremes, first byte on top.
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h00));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'hFF));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h01));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h02));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h03));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h04));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h05));
    plan.push_back(checked_row(8'h06, 64'h00FF_0102_0304_0506, 1'b0, 1'b0));
    plan.push_back(item_row(mdp_pkg::OP_FINISH, 8'hA5));
    // Small blocks, wide little-endian length, and a limit of one byte.
    plan.push_back(cfg_row(mdp_pkg::REG_BLOCK_SIZE, 7'(mdp_pkg::BS_16)));
    plan.push_back(cfg_row(mdp_pkg::REG_LENGTH_WIDE, 7'd1));
    plan.push_back(cfg_row(mdp_pkg::REG_LENGTH_BIG, 7'd0));
    plan.push_back(cfg_row(mdp_pkg::REG_LIMIT_EXP, 7'd1));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'h5A));
    plan.push_back(checked_row(8'h77, 64'h0, 1'b1, 1'b1));
    plan.push_back(checked_row(8'h00, 64'h0, 1'b1, 1'b1));
    plan.push_back(item_row(mdp_pkg::OP_FINISH, 8'h00));
    // Unused block code and the largest exponent.
    plan.push_back(cfg_row(mdp_pkg::REG_BLOCK_SIZE, 7'd3));
    plan.push_back(cfg_row(mdp_pkg::REG_LENGTH_WIDE, 7'd0));
    plan.push_back(cfg_row(mdp_pkg::REG_LENGTH_BIG, 7'd1));
    plan.push_back(cfg_row(mdp_pkg::REG_LIMIT_EXP, 7'd127));
    plan.push_back(item_row(mdp_pkg::OP_DATA, 8'hC3));
    plan.push_back(item_row(mdp_pkg::OP_FINISH, 8'h00));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain(SETTLE_CYCLES);
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_item(plan[i].op, plan[i].data_byte, plan[i].kind == ROW_CHECKED, plan[i].want);
      end
    end

    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      bsize = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       lexp = 7'd0;
        1:       lexp = 7'($urandom_range(1, 8));
        2:       lexp = 7'd127;
        3:       lexp = 7'd125;
        4:       lexp = 7'd61;
        default: lexp = 7'($urandom_range(4, 12));
      endcase
      // The first two phases shrink the block in the middle of a message.
      if (phase == 0) begin
        bsize = mdp_pkg::BS_128;
        lexp = 7'd0;
      end else if (phase == 1) begin
        bsize = mdp_pkg::BS_16;
        lexp = 7'd0;
      end
      drain(SETTLE_CYCLES);
      write_reg(mdp_pkg::REG_BLOCK_SIZE, 7'(bsize));
      write_reg(mdp_pkg::REG_LENGTH_WIDE, 7'($urandom_range(0, 1)));
      write_reg(mdp_pkg::REG_LENGTH_BIG, 7'($urandom_range(0, 1)));
      write_reg(mdp_pkg::REG_LIMIT_EXP, lexp);

      rx_mode = rx_mode_t'($urandom_range(0, 3));
      tx_idle = ($urandom_range(0, 2) != 0);
      // One phase holds the receiver off while a long message keeps coming.
      if (phase == 2) begin
        tx_idle = 1'b0;
        hold_req = 1'b1;
        send_message($urandom_range(48, 80));
      end

      quota = items_sent + $urandom_range(30, 50);
      while (items_sent < quota) begin
        if ($urandom_range(0, 7) == 0) len = $urandom_range(40, 140);
        else len = $urandom_range(0, 24);
        send_message(len);
        if ($urandom_range(0, 11) == 0) drain(0);
      end

      // Leave a partial message open across the next configuration change.
      if (phase == 0) repeat (40) send_byte();
      else if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 30)) send_byte();
      phase++;
    end

    drain(SETTLE_CYCLES);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mdp_pkg.sv
rtl/mdp_fifo.sv
rtl/mdp_front.sv
rtl/mdp_back.sv
rtl/merkle_damgard_padder_top.sv
dv/tb_top.sv
